### hw/rtl/signed_int_to_decimal_ascii_assert.svh
// Assertion macros used by the controller of the decimal text converter.
// Each macro checks an implication on the rising clock edge and is held off
// while reset is asserted.
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_ASSERT_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_ASSERT_SVH

`ifndef SYNTHESIS

`define SIDA_ASSERT_SAME(lbl, clk_i, rstn_i, ante, cons, msg) \
    lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |-> (cons)) \
        else $error(msg);

`define SIDA_ASSERT_NEXT(lbl, clk_i, rstn_i, ante, cons, msg) \
    lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |=> (cons)) \
        else $error(msg);

`else

`define SIDA_ASSERT_SAME(lbl, clk_i, rstn_i, ante, cons, msg)

`define SIDA_ASSERT_NEXT(lbl, clk_i, rstn_i, ante, cons, msg)

`endif

`endif

### hw/rtl/sida_pkg.sv
package sida_pkg;

    localparam int VALUE_WIDTH_DEF = 64;
    localparam int FIELD_WIDTH     = 64;
    localparam int DIGIT_DEPTH     = 19;
    localparam int COUNT_W         = 5;
    localparam int CODE_W          = 6;
    localparam int BITS_PER_STEP   = 4;

    localparam logic [CODE_W-1:0] ASCII_ZERO  = 6'd48;
    localparam logic [CODE_W-1:0] ASCII_MINUS = 6'd45;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic shift;
        logic count;
        logic take;
    } sida_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic shift_done;
        logic emit_last;
    } sida_stat_t;

    // Double-dabble correction of one BCD digit before it is doubled.
    function automatic logic [3:0] bcd_adjust(input logic [3:0] digit);
        logic [3:0] res;
        begin
            res = (digit >= 4'd5) ? digit + 4'd3 : digit;
            return res;
        end
    endfunction

endpackage

### hw/rtl/sida_datapath.sv
module sida_datapath
    import sida_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [FIELD_WIDTH-1:0] value,
    input  sida_cmd_t              cmd,
    output sida_stat_t             stat,
    output logic [CODE_W-1:0]      char_code,
    output logic                   last
);

    localparam int STEPS  = (VALUE_WIDTH + BITS_PER_STEP - 1) / BITS_PER_STEP;
    localparam int PAD_W  = STEPS * BITS_PER_STEP;
    localparam int STEP_W = (STEPS > 1) ? $clog2(STEPS) : 1;
    localparam int BCD_W  = DIGIT_DEPTH * 4;

    logic [VALUE_WIDTH-1:0] raw;
    logic [VALUE_WIDTH-1:0] abs_val;

    logic [PAD_W-1:0]   mag_reg, mag_next;
    logic [BCD_W-1:0]   bcd_reg, bcd_next;
    logic [STEP_W-1:0]  step_reg, step_next;
    logic [COUNT_W-1:0] idx_reg, idx_next;
    logic               sign_pend_reg, sign_pend_next;

    logic [BCD_W-1:0]   bcd_shifted;
    logic [COUNT_W-1:0] top_idx;
    logic [3:0]         cur_digit;

    assign raw     = value[VALUE_WIDTH-1:0];
    assign abs_val = raw[VALUE_WIDTH-1] ? (~raw + 1'b1) : raw;

    // Four double-dabble steps per cycle, each one adjust layer and a shift.
    always_comb
    begin
        bcd_shifted = bcd_reg;
        for (int b = 0; b < BITS_PER_STEP; b++)
        begin
            for (int d = 0; d < DIGIT_DEPTH; d++)
            begin
                bcd_shifted[d*4 +: 4] = bcd_adjust(bcd_shifted[d*4 +: 4]);
            end
            bcd_shifted = {bcd_shifted[BCD_W-2:0], mag_reg[PAD_W-1-b]};
        end
    end

    // Index of the most significant non-zero digit; zero gives digit 0.
    always_comb
    begin
        top_idx = '0;
        for (int d = 1; d < DIGIT_DEPTH; d++)
        begin
            if (bcd_reg[d*4 +: 4] != 4'd0)
            begin
                top_idx = COUNT_W'(d);
            end
        end
    end

    always_comb
    begin
        mag_next       = mag_reg;
        bcd_next       = bcd_reg;
        step_next      = step_reg;
        idx_next       = idx_reg;
        sign_pend_next = sign_pend_reg;
        if (cmd.load)
        begin
            mag_next       = PAD_W'(abs_val);
            bcd_next       = '0;
            step_next      = '0;
            sign_pend_next = raw[VALUE_WIDTH-1];
        end
        else if (cmd.shift)
        begin
            mag_next  = mag_reg << BITS_PER_STEP;
            bcd_next  = bcd_shifted;
            step_next = step_reg + 1'b1;
        end
        else if (cmd.count)
        begin
            idx_next = top_idx;
        end
        else if (cmd.take)
        begin
            if (sign_pend_reg)
            begin
                sign_pend_next = 1'b0;
            end
            else if (idx_reg != '0)
            begin
                idx_next = idx_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mag_reg       <= '0;
            step_reg      <= '0;
            idx_reg       <= '0;
            sign_pend_reg <= 1'b0;
        end
        else
        begin
            mag_reg       <= mag_next;
            step_reg      <= step_next;
            idx_reg       <= idx_next;
            sign_pend_reg <= sign_pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bcd_reg <= bcd_next;
    end

    assign cur_digit = bcd_reg[idx_reg*4 +: 4];
    assign char_code = sign_pend_reg ? ASCII_MINUS : (ASCII_ZERO + {2'b00, cur_digit});
    assign last      = !sign_pend_reg && (idx_reg == '0);

    assign stat.shift_done = (step_reg == STEP_W'(STEPS - 1));
    assign stat.emit_last  = last;

endmodule

### hw/rtl/sida_ctrl.sv
`include "signed_int_to_decimal_ascii_assert.svh"

module sida_ctrl
    import sida_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    output logic       out_valid,
    input  logic       out_stall,
    input  sida_stat_t stat,
    output sida_cmd_t  cmd
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_CONV  = 4'b0010,
        S_COUNT = 4'b0100,
        S_EMIT  = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        out_valid  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_CONV;
                end
            end
            S_CONV:
            begin
                cmd.shift = 1'b1;
                if (stat.shift_done)
                begin
                    state_next = S_COUNT;
                end
            end
            S_COUNT:
            begin
                cmd.count  = 1'b1;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                out_valid = 1'b1;
                if (!out_stall)
                begin
                    cmd.take = 1'b1;
                    if (stat.emit_last)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    `SIDA_ASSERT_NEXT(a_load_starts_conv, clk, rst_n, in_valid && !in_stall, state_reg == S_CONV, "accepted word did not start a conversion")
    `SIDA_ASSERT_SAME(a_no_accept_while_emit, clk, rst_n, out_valid, in_stall, "input open while characters are being sent")
    `SIDA_ASSERT_NEXT(a_last_ends_run, clk, rst_n, out_valid && !out_stall && stat.emit_last, state_reg == S_IDLE && !out_valid, "run did not end after its last character")

endmodule

### hw/rtl/signed_int_to_decimal_ascii.sv
// Signed integer to decimal text converter.
//
// The input channel (in_valid, in_stall, value) takes one signed integer per
// word; only the low VALUE_WIDTH bits are used, sign-extended from the top one.
// The output channel (out_valid, out_stall, char_code, last) returns its
// decimal text, one ASCII character per word, most significant first: a
// leading '-' for a negative value, then the digits, with last set on the
// final digit. Zero gives the single character '0', and the most negative
// value is printed in full because its magnitude is formed unsigned.
//
// Timing: after a word is accepted the magnitude is converted to BCD by a
// double-dabble unit that takes four bits per cycle, then a count state finds
// the leading digit. The characters then follow one per cycle while the
// receiver does not stall. One value is handled at a time: in_stall stays
// high from acceptance until its last character. A stalled receiver simply
// holds the current character, which stays stable. Reset returns the block
// to idle with the input open and no output valid.
module signed_int_to_decimal_ascii
    import sida_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [FIELD_WIDTH-1:0] value,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [CODE_W-1:0]      char_code,
    output logic                   last
);

    sida_cmd_t  cmd;
    sida_stat_t stat;

    // The controller sequences load, conversion, digit count and emission.
    sida_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    // The datapath holds the magnitude, the BCD digits and the emit pointer.
    sida_datapath #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .value     (value),
        .cmd       (cmd),
        .stat      (stat),
        .char_code (char_code),
        .last      (last)
    );

endmodule

### test/tb.sv
module tb;
    import sida_pkg::*;

    localparam int DIRECTED_ROWS = 22;
    localparam int RANDOM_WORDS  = 388;
    localparam int CALM_WORDS    = 50;     // final stretch with no idling on either side
    localparam int LONG_HOLD     = 300;    // receiver hold-off, in cycles
    localparam int DRAIN_CYCLES  = 60;
    localparam int CYCLE_LIMIT   = 400000;

    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic              last;
    } ascii_char_t;

    logic                   clk;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_stall;
    logic [FIELD_WIDTH-1:0] value;
    logic                   out_valid;
    logic                   out_stall;
    logic [CODE_W-1:0]      char_code;
    logic                   last;

    ascii_char_t            pending_chars[$];
    int                     mismatches;
    int                     cycles;
    bit                     calm;
    bit                     hold_long;

    logic [FIELD_WIDTH-1:0] row_value [DIRECTED_ROWS];
    string                  row_text  [DIRECTED_ROWS];

    signed_int_to_decimal_ascii u_top
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .value     (value),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .char_code (char_code),
        .last      (last)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("signed_int_to_decimal_ascii verification failed");
            $finish;
        end
    end

    // Works out the decimal text of one word: the magnitude is taken as an
    // unsigned number, so the most negative value prints in full.
    function automatic void predict_text(input logic [FIELD_WIDTH-1:0] word_value);
        logic [FIELD_WIDTH-1:0] mag;
        logic [3:0]             digits [DIGIT_DEPTH];
        int                     n;
        int                     k;
        ascii_char_t            c;
        mag = word_value[FIELD_WIDTH-1] ? (~word_value + 1'b1) : word_value;
        n = 0;
        do
        begin
            digits[n] = 4'(mag % 64'd10);
            mag       = mag / 64'd10;
            n++;
        end
        while (mag != 0 && n < DIGIT_DEPTH);
        if (word_value[FIELD_WIDTH-1])
        begin
            c.code = ASCII_MINUS;
            c.last = 1'b0;
            pending_chars.push_back(c);
        end
        for (k = n - 1; k >= 0; k--)
        begin
            c.code = ASCII_ZERO + {2'b00, digits[k]};
            c.last = (k == 0);
            pending_chars.push_back(c);
        end
    endfunction

    // Text typed into the table is queued as it stands; an empty entry
    // leaves the expectation to the predictor.
    function automatic void queue_text(input logic [FIELD_WIDTH-1:0] word_value,
                                       input string text);
        ascii_char_t c;
        int          i;
        byte         ch;
        if (text.len() == 0)
            predict_text(word_value);
        else
        begin
            for (i = 0; i < text.len(); i++)
            begin
                ch     = text[i];
                c.code = ch[CODE_W-1:0];
                c.last = (i == text.len() - 1);
                pending_chars.push_back(c);
            end
        end
    endfunction

    // Offers one word, after an optional idle burst, and holds it until taken.
    task automatic send_word(input logic [FIELD_WIDTH-1:0] word_value, input string text);
        int unsigned gap;
        gap = (!calm && $urandom_range(0, 3) == 0) ? $urandom_range(1, 8) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        value    <= word_value;
        do
            @(posedge clk);
        while (in_stall);
        queue_text(word_value, text);
    endtask

    // Random words spread over all digit counts: full-width patterns, bit lengths
    // from 1 to 63, small numbers, and values either side of a power of ten.
    function automatic logic [FIELD_WIDTH-1:0] pick_value();
        logic [FIELD_WIDTH-1:0] v;
        logic [FIELD_WIDTH-1:0] p;
        int unsigned            nbits;
        v = {$urandom, $urandom};
        case ($urandom_range(0, 3))
            0: ;
            1:
            begin
                nbits = $urandom_range(1, 63);
                v     = v & ((64'd1 << nbits) - 64'd1);
            end
            2: v = 64'($urandom_range(0, 1000));
            default:
            begin
                p = 64'd1;
                repeat ($urandom_range(0, 18)) p = p * 64'd10;
                v = p - 64'd1 + 64'($urandom_range(0, 2));
            end
        endcase
        if ($urandom_range(0, 1) == 1)
            v = ~v + 1'b1;
        return v;
    endfunction

    // Receiver: random stall bursts, and one long hold-off on request.
    initial
    begin : receiver
        int unsigned burst;
        forever
        begin
            @(negedge clk);
            if (hold_long)
            begin
                hold_long = 1'b0;
                burst     = LONG_HOLD;
            end
            else if (!calm && $urandom_range(0, 4) == 0)
                burst = $urandom_range(1, 8);
            else
                burst = 0;
            if (burst > 0)
            begin
                out_stall <= 1'b1;
                repeat (burst) @(negedge clk);
            end
            out_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin : check_chars
        ascii_char_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_chars.size() == 0)
            begin
                mismatches++;
                $display("%0t: character with none expected: code %0d last %0b",
                         $time, char_code, last);
            end
            else
            begin
                want = pending_chars.pop_front();
                if (char_code !== want.code)
                begin
                    mismatches++;
                    $display("%0t: char_code expected %0d actual %0d",
                             $time, want.code, char_code);
                end
                if (last !== want.last)
                begin
                    mismatches++;
                    $display("%0t: last expected %0b actual %0b",
                             $time, want.last, last);
                end
            end
        end
    end

    initial
    begin : stimulus
        int i;
        clk        = 1'b0;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        value      = '0;
        out_stall  = 1'b0;
        mismatches = 0;
        cycles     = 0;
        calm       = 1'b0;
        hold_long  = 1'b0;

        // Extremes carry their text; the rest go to the predictor.
        row_value[0]  = 64'd0;                   row_text[0]  = "0";
        row_value[1]  = 64'd1;                   row_text[1]  = "1";
        row_value[2]  = '1;                      row_text[2]  = "-1";
        row_value[3]  = 64'h7FFF_FFFF_FFFF_FFFF; row_text[3]  = "9223372036854775807";
        row_value[4]  = 64'h8000_0000_0000_0000; row_text[4]  = "-9223372036854775808";
        row_value[5]  = 64'h8000_0000_0000_0001; row_text[5]  = "-9223372036854775807";
        row_value[6]  = 64'd9;                   row_text[6]  = "";
        row_value[7]  = 64'd10;                  row_text[7]  = "";
        row_value[8]  = -64'd10;                 row_text[8]  = "";
        row_value[9]  = 64'd99;                  row_text[9]  = "";
        row_value[10] = 64'd100;                 row_text[10] = "";
        row_value[11] = 64'd1234567890;          row_text[11] = "";
        row_value[12] = -64'd987654321;          row_text[12] = "";
        row_value[13] = 64'd999999999999999999;  row_text[13] = "";
        row_value[14] = 64'd1000000000000000000; row_text[14] = "";
        row_value[15] = -64'd1000000000000000000; row_text[15] = "";
        row_value[16] = 64'h5555_5555_5555_5555; row_text[16] = "";
        row_value[17] = 64'hAAAA_AAAA_AAAA_AAAA; row_text[17] = "";
        row_value[18] = 64'h0000_0001_0000_0000; row_text[18] = "";
        row_value[19] = 64'hFFFF_FFFF_0000_0000; row_text[19] = "";
        row_value[20] = 64'd5;                   row_text[20] = "";
        row_value[21] = -64'd8;                  row_text[21] = "";

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (i = 0; i < DIRECTED_ROWS; i++)
            send_word(row_value[i], row_text[i]);

        // The sender rests until the block has returned every character.
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_chars.size() != 0)
            @(posedge clk);

        // The receiver holds off for a long stretch while words keep coming,
        // so the block backs up and stalls its input.
        hold_long = 1'b1;
        for (i = 0; i < RANDOM_WORDS; i++)
        begin
            if (i == RANDOM_WORDS - CALM_WORDS)
                calm = 1'b1;
            send_word(pick_value(), "");
        end
        @(negedge clk);
        in_valid <= 1'b0;

        while (pending_chars.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && pending_chars.size() == 0)
            $display("signed_int_to_decimal_ascii verification clean");
        else
            $display("signed_int_to_decimal_ascii verification failed");
        $finish;
    end

endmodule
